FILE: sv/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and helpers for pressure/temperature compensation
// Sequencer states, micro-step codes and arithmetic shift helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package ptc_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_TEMP_TRIM  = 3'd0;
	localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
	localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
	localparam logic [2:0] REG_PRESS_LAST = 3'd3;

	localparam logic OP_TEMPERATURE = 1'b0;
	localparam logic OP_PRESSURE    = 1'b1;

	localparam logic [63:0] FINE_OFFSET = 64'd128000;
	localparam logic [63:0] ADC_FULL    = 64'd1048576;
	localparam logic [63:0] DIV_SCALE   = 64'd3125;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_MUL,
		S_DSTART,
		S_DIV,
		S_FIN
	} state_t;

	// Micro-steps; each one is a single pass through the shared multiplier
	typedef enum logic [3:0] {
		TS_A,
		TS_D,
		TS_Y,
		PS_SQ,
		PS_V2A,
		PS_V2B,
		PS_W1,
		PS_W2,
		PS_W3,
		PS_NUM,
		PS_S,
		PS_X1,
		PS_V2C
	} step_t;

	function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
		return 64'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [63:0] sx16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

endpackage
`default_nettype wire

FILE: sv/ptc_mul.sv
// ----------------------------------------------------------------------------
// ptc_mul: 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier stepped over three partial products.
// ----------------------------------------------------------------------------
`default_nettype none
module ptc_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      prod
);

	logic [63:0] a_q, b_q, acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q, done_q;
	logic [31:0] ma, mb;
	logic [63:0] m;

	// partial product select: lo*lo, lo*hi, hi*lo
	always_comb begin
		case (cnt_q)
			2'd0: begin
				ma = a_q[31:0];
				mb = b_q[31:0];
			end
			2'd1: begin
				ma = a_q[31:0];
				mb = b_q[63:32];
			end
			default: begin
				ma = a_q[63:32];
				mb = b_q[31:0];
			end
		endcase
		m = ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= busy_q && (cnt_q == 2'd2);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) busy_q <= 1'b0;
			end
		end
	end

	// operand latch and accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (cnt_q == 2'd0) acc_q <= m;
			else acc_q[63:32] <= acc_q[63:32] + m[31:0];
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

FILE: sv/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div: signed 64-bit divider, truncating toward zero
// Restoring radix-2 loop on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ptc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [63:0] den,
	output logic             done,
	output logic [63:0]      quo
);

	logic [63:0] rem_q, quo_q, den_q;
	logic        neg_q, busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q[62:0], quo_q[63]};
	assign fits   = rem_sh >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) busy_q <= 1'b0;
			end
		end
	end

	// magnitude load, then one shift-subtract step a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num[63] ? 64'(0 - num) : num;
			den_q <= den[63] ? 64'(0 - den) : den;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - den_q : rem_sh;
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? 64'(0 - quo_q) : quo_q;

endmodule
`default_nettype wire

FILE: sv/pressure_temperature_compensation_top.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top: integer sensor compensation
// Temperature and pressure compensation on one shared multiplier and divider.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): operation selects temperature (0) or
//    pressure (1); raw_sample is the 20-bit converter reading.
//  - Output channel (out_valid/out_ready): one result per input transaction.
//  - cfg_write/cfg_index/cfg_data load the trim registers; write only while
//    idle. Unknown indexes are ignored.
//  - Sequence: a temperature item runs three multiplier passes, then the
//    final state. A pressure item runs ten multiplier passes and the
//    radix-2 64-bit divider. A zero divisor ends it after six passes.
//  - One item is in work at a time; in_ready is high only while the
//    sequencer is idle, so a new item is taken only once the last one has
//    left the final state. The finished result sits in an output register,
//    so the next item is taken while it waits for out_ready.
//  - A stalled receiver holds the result; a newer result waits in the final
//    state until the output register frees up.
//  - Reset clears trims, fine temperature and all control state.
// ----------------------------------------------------------------------------
`default_nettype none
module pressure_temperature_compensation_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [19:0] raw_sample,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             reading_kind,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]      pressure_q24_8,
	output logic             zero_divisor
);

	ptc_pkg::state_t state_q, state_d;
	ptc_pkg::step_t  step_q, step_d;

	logic [47:0] ttrim_q;
	logic [63:0] plow_q, phigh_q;
	logic [15:0] plast_q;
	logic [31:0] fine_q;

	logic        op_q, zero_q;
	logic [19:0] adc_q;
	logic [63:0] sq_q, v2_q, w_q, p_q;

	logic        mul_start, mul_done, div_start, div_done;
	logic [63:0] mul_a, mul_b, prod, quo;
	logic [63:0] w3_next;
	logic        fin_take;

	logic        out_valid_q, kind_q, zflag_q;
	logic [31:0] temp_q, press_q;

	// ---------------- configuration registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttrim_q <= '0;
			plow_q  <= '0;
			phigh_q <= '0;
			plast_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				ptc_pkg::REG_TEMP_TRIM:  ttrim_q <= cfg_data[47:0];
				ptc_pkg::REG_PRESS_LOW:  plow_q  <= cfg_data;
				ptc_pkg::REG_PRESS_HIGH: phigh_q <= cfg_data;
				ptc_pkg::REG_PRESS_LAST: plast_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ---------------- trim fields and derived operands ----------------
	logic [31:0] t1, t2, t3, adc32, ta, td;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, s_val, num_val;

	always_comb begin
		t1      = {16'b0, ttrim_q[15:0]};
		t2      = {{16{ttrim_q[31]}}, ttrim_q[31:16]};
		t3      = {{16{ttrim_q[47]}}, ttrim_q[47:32]};
		adc32   = {12'b0, adc_q};
		ta      = (adc32 >> 3) - (t1 << 1);
		td      = (adc32 >> 4) - t1;
		p1      = {48'b0, plow_q[15:0]};
		p2      = ptc_pkg::sx16(plow_q[31:16]);
		p3      = ptc_pkg::sx16(plow_q[47:32]);
		p4      = ptc_pkg::sx16(plow_q[63:48]);
		p5      = ptc_pkg::sx16(phigh_q[15:0]);
		p6      = ptc_pkg::sx16(phigh_q[31:16]);
		p7      = ptc_pkg::sx16(phigh_q[47:32]);
		p8      = ptc_pkg::sx16(phigh_q[63:48]);
		p9      = ptc_pkg::sx16(plast_q);
		v1      = {{32{fine_q[31]}}, fine_q} - ptc_pkg::FINE_OFFSET;
		s_val   = ptc_pkg::asr64(p_q, 13);
		num_val = ((ptc_pkg::ADC_FULL - {44'b0, adc_q}) << 31) - v2_q;
	end

	// ---------------- operand select per step ----------------
	always_comb begin
		case (step_q)
			ptc_pkg::TS_A: begin
				mul_a = {32'b0, ta};
				mul_b = {32'b0, t2};
			end
			ptc_pkg::TS_D: begin
				mul_a = {32'b0, td};
				mul_b = {32'b0, td};
			end
			ptc_pkg::TS_Y: begin
				mul_a = {32'b0, sq_q[31:0]};
				mul_b = {32'b0, t3};
			end
			ptc_pkg::PS_SQ: begin
				mul_a = v1;
				mul_b = v1;
			end
			ptc_pkg::PS_V2A: begin
				mul_a = sq_q;
				mul_b = p6;
			end
			ptc_pkg::PS_V2B: begin
				mul_a = v1;
				mul_b = p5;
			end
			ptc_pkg::PS_W1: begin
				mul_a = sq_q;
				mul_b = p3;
			end
			ptc_pkg::PS_W2: begin
				mul_a = v1;
				mul_b = p2;
			end
			ptc_pkg::PS_W3: begin
				mul_a = (64'd1 << 47) + w_q;
				mul_b = p1;
			end
			ptc_pkg::PS_NUM: begin
				mul_a = num_val;
				mul_b = ptc_pkg::DIV_SCALE;
			end
			ptc_pkg::PS_S: begin
				mul_a = s_val;
				mul_b = s_val;
			end
			ptc_pkg::PS_X1: begin
				mul_a = p9;
				mul_b = sq_q;
			end
			default: begin
				mul_a = p8;
				mul_b = p_q;
			end
		endcase
	end

	assign w3_next = ptc_pkg::asr64(prod, 33);

	ptc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	ptc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p_q),
		.den    (w_q),
		.done   (div_done),
		.quo    (quo)
	);

	// ---------------- sequencer next state ----------------
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			ptc_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = ptc_pkg::S_ISSUE;
					step_d  = (operation == ptc_pkg::OP_PRESSURE) ? ptc_pkg::PS_SQ
					                                               : ptc_pkg::TS_A;
				end
			end
			ptc_pkg::S_ISSUE: state_d = ptc_pkg::S_MUL;
			ptc_pkg::S_MUL: begin
				if (mul_done) begin
					if (step_q == ptc_pkg::TS_Y || step_q == ptc_pkg::PS_V2C) begin
						state_d = ptc_pkg::S_FIN;
					end else if (step_q == ptc_pkg::PS_W3 && w3_next == 64'd0) begin
						state_d = ptc_pkg::S_FIN;
					end else if (step_q == ptc_pkg::PS_NUM) begin
						state_d = ptc_pkg::S_DSTART;
					end else begin
						state_d = ptc_pkg::S_ISSUE;
						step_d  = ptc_pkg::step_t'(step_q + 4'd1);
					end
				end
			end
			ptc_pkg::S_DSTART: state_d = ptc_pkg::S_DIV;
			ptc_pkg::S_DIV: begin
				if (div_done) begin
					state_d = ptc_pkg::S_ISSUE;
					step_d  = ptc_pkg::PS_S;
				end
			end
			ptc_pkg::S_FIN: begin
				if (fin_take) state_d = ptc_pkg::S_IDLE;
			end
			default: state_d = ptc_pkg::S_IDLE;
		endcase
	end

	// ---------------- sequencer outputs ----------------
	always_comb begin
		in_ready  = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		fin_take  = 1'b0;
		case (state_q)
			ptc_pkg::S_IDLE:   in_ready  = 1'b1;
			ptc_pkg::S_ISSUE:  mul_start = 1'b1;
			ptc_pkg::S_DSTART: div_start = 1'b1;
			ptc_pkg::S_FIN:    fin_take  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptc_pkg::S_IDLE;
			step_q  <= ptc_pkg::TS_A;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// ---------------- fine temperature (state) ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q <= '0;
		end else if (state_q == ptc_pkg::S_MUL && mul_done && step_q == ptc_pkg::TS_Y) begin
			fine_q <= w_q[31:0] + ptc_pkg::asr32(prod[31:0], 14);
		end
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= operation;
			adc_q  <= raw_sample;
			zero_q <= 1'b0;
		end
		if (state_q == ptc_pkg::S_DIV && div_done) p_q <= quo;
		if (state_q == ptc_pkg::S_MUL && mul_done) begin
			case (step_q)
				ptc_pkg::TS_A:   w_q  <= {32'b0, ptc_pkg::asr32(prod[31:0], 11)};
				ptc_pkg::TS_D:   sq_q <= {32'b0, ptc_pkg::asr32(prod[31:0], 12)};
				ptc_pkg::PS_SQ:  sq_q <= prod;
				ptc_pkg::PS_V2A: v2_q <= prod;
				ptc_pkg::PS_V2B: v2_q <= v2_q + (prod << 17) + (p4 << 35);
				ptc_pkg::PS_W1:  w_q  <= ptc_pkg::asr64(prod, 8);
				ptc_pkg::PS_W2:  w_q  <= w_q + (prod << 12);
				ptc_pkg::PS_W3: begin
					w_q    <= w3_next;
					zero_q <= (w3_next == 64'd0);
				end
				ptc_pkg::PS_NUM: p_q  <= prod;
				ptc_pkg::PS_S:   sq_q <= prod;
				ptc_pkg::PS_X1:  sq_q <= ptc_pkg::asr64(prod, 25);
				ptc_pkg::PS_V2C: v2_q <= ptc_pkg::asr64(prod, 19);
				default: ;
			endcase
		end
	end

	// ---------------- result formatting ----------------
	logic [31:0] t_res, p_res;
	logic [63:0] p_sum;

	always_comb begin
		t_res = ptc_pkg::asr32(fine_q + (fine_q << 2) + 32'd128, 8);
		p_sum = ptc_pkg::asr64(p_q + sq_q + v2_q, 8) + (p7 << 4);
		p_res = zero_q ? 32'd0 : p_sum[31:0];
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_take) begin
			kind_q  <= op_q;
			temp_q  <= (op_q == ptc_pkg::OP_PRESSURE) ? 32'd0 : t_res;
			press_q <= (op_q == ptc_pkg::OP_PRESSURE) ? p_res : 32'd0;
			zflag_q <= (op_q == ptc_pkg::OP_PRESSURE) && zero_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign reading_kind      = kind_q;
	assign temperature_centi = temp_q;
	assign pressure_q24_8    = press_q;
	assign zero_divisor      = zflag_q;

	// ---------------- assertions ----------------
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ptc_pkg::S_MUL)
		else $error("multiplier finished outside multiply state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ptc_pkg::S_DIV)
		else $error("divider finished outside divide state");

	a_zero_only_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptc_pkg::S_FIN && zero_q) |-> op_q == ptc_pkg::OP_PRESSURE)
		else $error("zero divisor flagged on temperature transaction");

	a_fin_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		fin_take |=> out_valid)
		else $error("finished result not presented");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: pressure/temperature compensation testbench
// Drives raw samples under random idling and receiver stalls, predicts each
// reading with an independent fixed-point model and checks every field.
// ----------------------------------------------------------------------------
`default_nettype none

// Expected reading for one transaction
typedef struct {
	logic        kind;
	logic [31:0] centi;
	logic [31:0] pascal;
	logic        zdiv;
} reading_t;

// Scoreboard: keeps trims and fine temperature, queues expected readings
class reading_board;
	logic [47:0] t_trim;
	logic [63:0] p_low, p_high;
	logic [15:0] p_last;
	logic [31:0] fine_t;
	reading_t    pending[$];
	int          errors, n_in, n_out, n_zdiv;

	function new();
		t_trim = 0; p_low = 0; p_high = 0; p_last = 0; fine_t = 0;
		errors = 0; n_in = 0; n_out = 0; n_zdiv = 0;
	endfunction

	function void write_trim(logic [2:0] idx, logic [63:0] d);
		case (idx)
			ptc_pkg::REG_TEMP_TRIM:  t_trim = d[47:0];
			ptc_pkg::REG_PRESS_LOW:  p_low = d;
			ptc_pkg::REG_PRESS_HIGH: p_high = d;
			ptc_pkg::REG_PRESS_LAST: p_last = d[15:0];
			default: ;
		endcase
	endfunction

	function logic [63:0] s16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// arithmetic right shift of a 64-bit pattern
	function logic [63:0] sra64(logic [63:0] x, int unsigned n);
		return $signed(x) >>> n;
	endfunction

	function logic [31:0] temp_centi(logic [19:0] adc);
		logic [31:0] t1, t2, t3, a, d, v1, v2;
		t1 = {16'd0, t_trim[15:0]};
		t2 = {{16{t_trim[31]}}, t_trim[31:16]};
		t3 = {{16{t_trim[47]}}, t_trim[47:32]};
		a = {15'd0, adc[19:3]} - (t1 << 1);
		v1 = $signed(a * t2) >>> 11;
		d = {16'd0, adc[19:4]} - t1;
		v2 = $signed(d * d) >>> 12;
		v2 = $signed(v2 * t3) >>> 14;
		fine_t = v1 + v2;
		return $signed(fine_t * 32'd5 + 32'd128) >>> 8;
	endfunction

	function logic [31:0] pressure(logic [19:0] adc, output logic zd);
		logic [63:0] p1, ft, v1, v2, p, s, num, un, ud, q;
		logic nn, nd;
		p1 = {48'd0, p_low[15:0]};
		ft = {{32{fine_t[31]}}, fine_t};
		v1 = ft - 64'd128000;
		v2 = v1 * v1 * s16(p_high[31:16]);
		v2 = v2 + ((v1 * s16(p_high[15:0])) << 17);
		v2 = v2 + (s16(p_low[63:48]) << 35);
		v1 = sra64(v1 * v1 * s16(p_low[47:32]), 8)
			+ ((v1 * s16(p_low[31:16])) << 12);
		v1 = $signed(((64'd1 << 47) + v1) * p1) >>> 33;
		zd = (v1 == 0);
		if (zd) return 0;
		p = 64'd1048576 - {44'd0, adc};
		num = ((p << 31) - v2) * 64'd3125;
		nn = num[63]; nd = v1[63];
		un = nn ? -num : num;
		ud = nd ? -v1 : v1;
		q = un / ud;
		p = (nn != nd) ? -q : q;
		s = $signed(p) >>> 13;
		v1 = $signed(s16(p_last) * s * s) >>> 25;
		v2 = $signed(s16(p_high[63:48]) * p) >>> 19;
		p = sra64(p + v1 + v2, 8) + (s16(p_high[47:32]) << 4);
		return p[31:0];
	endfunction

	function void note_input(logic op, logic [19:0] adc);
		reading_t r;
		logic zd;
		r.kind = op;
		r.centi = 0; r.pascal = 0; r.zdiv = 0;
		if (op == ptc_pkg::OP_TEMPERATURE) begin
			r.centi = temp_centi(adc);
		end else begin
			r.pascal = pressure(adc, zd);
			r.zdiv = zd;
			if (zd) n_zdiv++;
		end
		pending.push_back(r);
		n_in++;
	endfunction

	function void report(string what, logic [31:0] got, logic [31:0] want);
		$display("tb: mismatch on reading %0d, %s: got %h want %h", n_out, what, got, want);
		errors++;
	endfunction

	function void check_reading(logic k, logic [31:0] c, logic [31:0] p, logic z);
		reading_t e;
		if (pending.size() == 0) begin
			$display("tb: reading %0d arrived with none expected", n_out);
			errors++;
		end else begin
			e = pending.pop_front();
			if (k !== e.kind) report("kind", k, e.kind);
			if (c !== e.centi) report("temperature", c, e.centi);
			if (p !== e.pascal) report("pressure", p, e.pascal);
			if (z !== e.zdiv) report("zero_divisor", z, e.zdiv);
		end
		n_out++;
	endfunction
endclass

module tb;
	localparam int WATCHDOG = 20000;

	logic        clk, arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid, in_ready, operation;
	logic [19:0] raw_sample;
	logic        out_valid, out_ready, reading_kind, zero_divisor;
	logic signed [31:0] temperature_centi;
	logic [31:0] pressure_q24_8;

	reading_board board;
	int  send_idle, recv_stall;   // percent
	int  hold_off;                // cycles of forced receiver stall
	int  quiet;

	pressure_temperature_compensation_top uut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stalls plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready)
				board.check_reading(reading_kind, temperature_centi,
					pressure_q24_8, zero_divisor);
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// Watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("tb: watchdog expired");
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] d);
		@(posedge clk);
		cfg_write <= 1; cfg_index <= idx; cfg_data <= d;
		board.write_trim(idx, d);
		@(posedge clk);
		cfg_write <= 0;
	endtask

	// One input transaction; valid drops at acceptance and rises again in the following cycle at the earliest
	task automatic send(logic op, logic [19:0] adc);
		@(posedge clk);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		in_valid <= 1; operation <= op; raw_sample <= adc;
		do @(posedge clk); while (!in_ready);
		board.note_input(op, adc);
		in_valid <= 0;
	endtask

	// Wait for every reading, then let any in-flight work settle
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic set_trims(logic [47:0] t, logic [63:0] lo, logic [63:0] hi,
			logic [15:0] last);
		write_reg(ptc_pkg::REG_TEMP_TRIM, {16'd0, t});
		write_reg(ptc_pkg::REG_PRESS_LOW, lo);
		write_reg(ptc_pkg::REG_PRESS_HIGH, hi);
		write_reg(ptc_pkg::REG_PRESS_LAST, {48'd0, last});
	endtask

	// Typical factory trims with random jitter
	task automatic typical_trims();
		set_trims({16'hFC18 + 16'($urandom_range(0, 15)), 16'd26435,
				16'd27504 + 16'($urandom_range(0, 255))},
			{16'd2855, 16'hFFF9, 16'($signed(-10230)), 16'd36477},
			{16'hFFF9, 16'd15500, 16'($signed(-14600)), 16'hFFF9},
			16'd6000);
	endtask

	task automatic random_phase(int n, int idle, int stall);
		send_idle = idle; recv_stall = stall;
		repeat (n) begin
			if ($urandom_range(3) == 0)
				send(ptc_pkg::OP_TEMPERATURE, 20'($urandom));
			else if ($urandom_range(1) == 0)
				send(ptc_pkg::OP_PRESSURE, 20'($urandom));
			else
				send(1'($urandom_range(1)), 20'($urandom_range(300000, 700000)));
		end
		drain();
	endtask

	initial begin
		board = new();
		send_idle = 0; recv_stall = 0; hold_off = 0; quiet = 0;
		cfg_write = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; operation = 0; raw_sample = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// Pressure before any temperature, all trims zero: zero divisor
		send(ptc_pkg::OP_PRESSURE, 20'd0);
		send(ptc_pkg::OP_PRESSURE, 20'hFFFFF);
		send(ptc_pkg::OP_TEMPERATURE, 20'hFFFFF);
		drain();

		// Typical trims, mid-range and extreme raw samples
		typical_trims();
		send(ptc_pkg::OP_PRESSURE, 20'd415148);
		send(ptc_pkg::OP_TEMPERATURE, 20'd519888);
		send(ptc_pkg::OP_PRESSURE, 20'd415148);
		send(ptc_pkg::OP_TEMPERATURE, 20'd0);
		send(ptc_pkg::OP_PRESSURE, 20'd0);
		send(ptc_pkg::OP_TEMPERATURE, 20'hFFFFF);
		send(ptc_pkg::OP_PRESSURE, 20'hFFFFF);
		send(ptc_pkg::OP_PRESSURE, 20'h55555);
		send(ptc_pkg::OP_PRESSURE, 20'hAAAAA);
		drain();

		// All-ones trims, then extreme signed trims (wrap paths)
		set_trims({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'hFFFF);
		send(ptc_pkg::OP_TEMPERATURE, 20'hFFFFF);
		send(ptc_pkg::OP_PRESSURE, 20'd0);
		send(ptc_pkg::OP_TEMPERATURE, 20'd0);
		send(ptc_pkg::OP_PRESSURE, 20'hFFFFF);
		drain();
		set_trims({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
			{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
		send(ptc_pkg::OP_TEMPERATURE, 20'h12345);
		send(ptc_pkg::OP_PRESSURE, 20'h80000);
		send(ptc_pkg::OP_PRESSURE, 20'h7FFFF);
		drain();

		// Random phases over several idling mixes and trim settings
		typical_trims();
		random_phase(250, 0, 0);
		set_trims(48'($urandom) | (48'($urandom) << 32), {$urandom, $urandom},
			{$urandom, $urandom}, 16'($urandom));
		random_phase(150, 51, 0);
		typical_trims();
		random_phase(200, 0, 51);
		set_trims({16'($urandom), 16'($urandom), 16'($urandom_range(0, 100))},
			{$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
		random_phase(150, 27, 27);

		// Long receiver hold-off while the sender keeps offering items
		typical_trims();
		hold_off = 600;
		send_idle = 0;
		repeat (6) send(ptc_pkg::OP_PRESSURE, 20'($urandom));
		drain();
		random_phase(200, 27, 27);

		$display("tb: %0d samples compensated, %0d readings checked, %0d zero divisors",
			board.n_in, board.n_out, board.n_zdiv);
		$display("tb: covered trim extremes, wrap cases and idle/stall mixes");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
